// ===== sv/two_link_arm_inverse_kinematics_macros.svh =====
// Assertion macros shared by the inverse kinematics RTL.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH

// Same-cycle implication.
`define IKA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IKA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ika_pkg.sv =====
// Types, widths and constants of the inverse kinematics block.
`timescale 1ns / 1ps
package ika_pkg;

  localparam int CORDIC_STEPS     = 20;
  localparam int PULSE_WIDTH_BITS = 12;

  localparam int LEN_W      = 15;
  localparam int REACH_W    = 16;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int N_W        = 34;   // cosine-law numerators
  localparam int RAD_W      = 64;   // sqrt radicand
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 36;
  localparam int SQRT_STEPS = 32;

  localparam int VIN_W       = 36;  // cordic operands
  localparam int CW          = 42;  // cordic datapath
  localparam int M_W         = 39;  // normalized magnitude, top bit at 2^38
  localparam int ZW          = 36;  // binary angle, 2^32 per turn
  localparam int NORM_STAGES = 6;
  localparam int CORDIC_LAT  = 1 + NORM_STAGES + CORDIC_STEPS;

  localparam logic signed [ZW-1:0] HALF_TURN = 36'sh080000000;

  localparam logic [29:0] ARC_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // pulse = (offset*2^32 -/+ GAIN*T) / (50*2^32)
  localparam logic [17:0] PULSE_GAIN  = 18'd164520;
  localparam int          U_W         = 24;
  localparam logic signed [U_W-1:0] SH_OFS = 24'sd109630;
  localparam logic signed [U_W-1:0] EL_OFS = 24'sd97500;
  localparam logic [20:0] RECIP       = 21'd1342178;  // ceil(2^26 / 50)
  localparam int          RECIP_SHIFT = 26;
  localparam int          PROD_W      = 41;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0]   LINK1_RST = 15'd1600;
  localparam logic [LEN_W-1:0]   LINK2_RST = 15'd1600;
  localparam logic [REACH_W-1:0] MIN_RST   = 16'd0;
  localparam logic [REACH_W-1:0] MAX_RST   = 16'd3200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK1     = 2'd0,
    REG_LINK2     = 2'd1,
    REG_MIN_REACH = 2'd2,
    REG_MAX_REACH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0]   link1;
    logic [LEN_W-1:0]   link2;
    logic [REACH_W-1:0] min_reach;
    logic [REACH_W-1:0] max_reach;
  } cfg_t;

  // Front-to-back work item.
  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [N_W-1:0]     n1;
    logic signed [N_W-1:0]     n2;
    logic [61:0]               d1a;  // a1^2 * r^2
    logic [59:0]               d2a;  // a1^2 * a2^2
  } work_t;

endpackage

// ===== sv/ika_if.sv =====
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface ika_in_if;
  import ika_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

interface ika_out_if;
  import ika_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        in_reach;
  logic [PULSE_WIDTH_BITS-1:0] pulse_shoulder;
  logic [PULSE_WIDTH_BITS-1:0] pulse_elbow;
  modport source (output valid, in_reach, pulse_shoulder, pulse_elbow, input ready);
  modport sink (input valid, in_reach, pulse_shoulder, pulse_elbow, output ready);
endinterface

interface ika_cfg_if;
  import ika_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/two_link_arm_inverse_kinematics.sv =====
// Top level of the two-link planar arm inverse kinematics block.
//
//   port   | role   | moves
//   req_i  | sink   | target_x, target_y
//   rsp_o  | source | in_reach, pulse_shoulder, pulse_elbow
//   cfg_i  | sink   | register index and write data, always ready
//
// Fully pipelined: one request per cycle sustained while results are taken.
// Stages with CORDIC_STEPS = 20: 4 front, queue, 2 radicand, 32 square root,
// 27 CORDIC, 6 pulse and output. The square root and CORDIC stage chains
// set the latency. A stalled result freezes the back end only; the queue
// keeps the front taking requests until it fills. No clearing pass after reset.
`timescale 1ns / 1ps
`include "two_link_arm_inverse_kinematics_macros.svh"
module two_link_arm_inverse_kinematics (
  input  logic      clk_i,
  input  logic      rst_ni,
  ika_in_if.sink    req_i,
  ika_out_if.source rsp_o,
  ika_cfg_if.sink   cfg_i
);
  import ika_pkg::*;

  cfg_t  cfg_q;
  work_t f_data, q_data;
  logic  q_push, q_pop, q_full, q_empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link1     <= LINK1_RST;
      cfg_q.link2     <= LINK2_RST;
      cfg_q.min_reach <= MIN_RST;
      cfg_q.max_reach <= MAX_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LINK1:     cfg_q.link1     <= cfg_i.data[LEN_W-1:0];
        REG_LINK2:     cfg_q.link2     <= cfg_i.data[LEN_W-1:0];
        REG_MIN_REACH: cfg_q.min_reach <= cfg_i.data[REACH_W-1:0];
        REG_MAX_REACH: cfg_q.max_reach <= cfg_i.data[REACH_W-1:0];
        default: ;
      endcase
    end
  end

  ika_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .req_i,
    .full_i(q_full), .push_o(q_push), .data_o(f_data)
  );

  ika_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(f_data), .pop_i(q_pop),
    .data_o(q_data), .full_o(q_full), .empty_o(q_empty)
  );

  ika_back u_back (
    .clk_i, .rst_ni, .head_valid_i(!q_empty), .head_i(q_data),
    .pop_o(q_pop), .rsp_o
  );

  `IKA_ASSERT_IMPL(a_unreach_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.in_reach, rsp_o.pulse_shoulder == '0 && rsp_o.pulse_elbow == '0, "out of reach result with nonzero pulse")
  `IKA_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !req_i.ready, q_full, "front stalled with room in queue")
  `IKA_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, q_full && !q_pop, q_full, "queue lost an entry without a pop")

endmodule

// ===== sv/ika_front.sv =====
// Front end: takes requests, squares, reach check and cosine-law terms.
`timescale 1ns / 1ps
module ika_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ika_pkg::cfg_t  cfg_i,
  ika_in_if.sink         req_i,
  input  logic           full_i,
  output logic           push_o,
  output ika_pkg::work_t data_o
);
  import ika_pkg::*;

  logic [3:0] v_q;
  logic       fen;

  logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [31:0] xx_q, yy_q, r2_q;
  logic [29:0] aa1_q, aa2_q, aa1b_q, aa2b_q;
  logic [31:0] mx2_q, mn2_q, mx2b_q, mn2b_q;
  work_t       out_q;

  assign fen         = !v_q[3] || !full_i;
  assign req_i.ready = fen;
  assign push_o      = v_q[3] && !full_i;
  assign data_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (fen) begin
      v_q <= {v_q[2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      x0_q <= req_i.target_x;
      y0_q <= req_i.target_y;

      x1_q   <= x0_q;
      y1_q   <= y0_q;
      xx_q   <= 32'(x0_q) * 32'(x0_q);
      yy_q   <= 32'(y0_q) * 32'(y0_q);
      aa1_q  <= 30'(cfg_i.link1) * 30'(cfg_i.link1);
      aa2_q  <= 30'(cfg_i.link2) * 30'(cfg_i.link2);
      mx2_q  <= 32'(cfg_i.max_reach) * 32'(cfg_i.max_reach);
      mn2_q  <= 32'(cfg_i.min_reach) * 32'(cfg_i.min_reach);

      x2_q   <= x1_q;
      y2_q   <= y1_q;
      r2_q   <= xx_q + yy_q;
      aa1b_q <= aa1_q;
      aa2b_q <= aa2_q;
      mx2b_q <= mx2_q;
      mn2b_q <= mn2_q;

      out_q.ok  <= (r2_q != '0) && (r2_q <= mx2b_q) && (r2_q >= mn2b_q);
      out_q.x   <= x2_q;
      out_q.y   <= y2_q;
      out_q.n1  <= N_W'(r2_q) + N_W'(aa1b_q) - N_W'(aa2b_q);
      out_q.n2  <= N_W'(r2_q) - N_W'(aa1b_q) - N_W'(aa2b_q);
      out_q.d1a <= 62'(aa1b_q) * 62'(r2_q);
      out_q.d2a <= 60'(aa1b_q) * 60'(aa2b_q);
    end
  end

endmodule

// ===== sv/ika_fifo.sv =====
// Short work queue between front and back ends.
`timescale 1ns / 1ps
module ika_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ika_pkg::work_t data_i,
  input  logic           pop_i,
  output ika_pkg::work_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import ika_pkg::*;

  work_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== sv/ika_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ika_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ika_pkg::RAD_W-1:0]  val_i,
  output logic [ika_pkg::ROOT_W-1:0] root_o
);
  import ika_pkg::*;

  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [RAD_W-1:0]  val_q  [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [REM_W-1:0]  pr, cur, trial;
    logic [ROOT_W-1:0] pq;
    logic [RAD_W-1:0]  pv;

    if (g == 0) begin : g_first
      assign pr = '0;
      assign pq = '0;
      assign pv = val_i;
    end else begin : g_next
      assign pr = rem_q[g-1];
      assign pq = root_q[g-1];
      assign pv = val_q[g-1];
    end

    assign cur   = {pr[REM_W-3:0], pv[RAD_W-1 -: 2]};
    assign trial = REM_W'({pq, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[g] <= pv << 2;
        if (cur >= trial) begin
          rem_q[g]  <= cur - trial;
          root_q[g] <= {pq[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[g]  <= cur;
          root_q[g] <= {pq[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule

// ===== sv/ika_cordic.sv =====
// Pipelined vectoring CORDIC: fold, normalize, then one rotation per stage.
`timescale 1ns / 1ps
module ika_cordic (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [ika_pkg::VIN_W-1:0] y_i,
  input  logic signed [ika_pkg::VIN_W-1:0] x_i,
  output logic signed [ika_pkg::ZW-1:0]    angle_o
);
  import ika_pkg::*;

  logic signed [CW-1:0] xs_q   [CORDIC_LAT];
  logic signed [CW-1:0] ys_q   [CORDIC_LAT];
  logic signed [ZW-1:0] z_q    [CORDIC_LAT];
  logic signed [ZW-1:0] base_q [CORDIC_LAT];
  logic [M_W-1:0]       m_q    [NORM_STAGES+1];

  logic signed [CW-1:0] fx, fy;
  logic signed [ZW-1:0] fb;
  logic [M_W-1:0]       ax, ay;

  // Left half plane folds onto the right by half a turn.
  always_comb begin
    fx = CW'(x_i);
    fy = CW'(y_i);
    fb = '0;
    if (x_i < 0) begin
      fb = (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      fx = -fx;
      fy = -fy;
    end
    ax = M_W'(fx);
    ay = (fy < 0) ? M_W'(-fy) : M_W'(fy);
  end

  for (genvar s = 0; s < CORDIC_LAT; s++) begin : g_stage
    if (s == 0) begin : g_fold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xs_q[0]   <= fx;
          ys_q[0]   <= fy;
          z_q[0]    <= '0;
          base_q[0] <= fb;
          m_q[0]    <= (ax > ay) ? ax : ay;
        end
      end
    end else if (s <= NORM_STAGES) begin : g_norm
      localparam int K = 1 << (NORM_STAGES - s);
      logic is_low;
      assign is_low = (m_q[s-1] >> (M_W - K)) == '0;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[s]    <= '0;
          base_q[s] <= base_q[s-1];
          if (is_low) begin
            xs_q[s] <= xs_q[s-1] <<< K;
            ys_q[s] <= ys_q[s-1] <<< K;
            m_q[s]  <= m_q[s-1] << K;
          end else begin
            xs_q[s] <= xs_q[s-1];
            ys_q[s] <= ys_q[s-1];
            m_q[s]  <= m_q[s-1];
          end
        end
      end
    end else begin : g_iter
      localparam int I = s - NORM_STAGES - 1;
      logic signed [CW-1:0] tx, ty;
      assign tx = xs_q[s-1] >>> I;
      assign ty = ys_q[s-1] >>> I;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          base_q[s] <= base_q[s-1];
          if (ys_q[s-1] > 0) begin
            xs_q[s] <= xs_q[s-1] + ty;
            ys_q[s] <= ys_q[s-1] - tx;
            z_q[s]  <= z_q[s-1] + ZW'(ARC_TAB[I]);
          end else if (ys_q[s-1] < 0) begin
            xs_q[s] <= xs_q[s-1] - ty;
            ys_q[s] <= ys_q[s-1] + tx;
            z_q[s]  <= z_q[s-1] - ZW'(ARC_TAB[I]);
          end else begin
            xs_q[s] <= xs_q[s-1];
            ys_q[s] <= ys_q[s-1];
            z_q[s]  <= z_q[s-1];
          end
        end
      end
    end
  end

  assign angle_o = base_q[CORDIC_LAT-1] + z_q[CORDIC_LAT-1];

endmodule

// ===== sv/ika_back.sv =====
// Back end: acos radicands, square roots, three CORDICs and pulse scaling.
`timescale 1ns / 1ps
module ika_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  ika_pkg::work_t head_i,
  output logic           pop_o,
  ika_out_if.source      rsp_o
);
  import ika_pkg::*;

  localparam int SIDE_LAT = 2 + SQRT_STEPS;
  localparam int TAIL     = 5;
  localparam int VLD_LEN  = SIDE_LAT + CORDIC_LAT + TAIL;
  localparam int PH_W     = ZW - 16 + 19;
  localparam int PL_W     = 34;
  localparam int P_W      = 56;
  localparam int Q_W      = PROD_W - RECIP_SHIFT;
  localparam int PULSE_MAX = (1 << PULSE_WIDTH_BITS) - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [N_W-1:0]     n1;
    logic signed [N_W-1:0]     n2;
  } side_t;

  logic               en;
  logic               out_v_q;
  logic [VLD_LEN-1:0] vld_q, ok_q;
  side_t              side_q [SIDE_LAT];
  side_t              side_last;

  logic [ROOT_W-1:0]  an1, an2;
  logic [RAD_W-1:0]   d1_q, d2_q, n1sq_q, n2sq_q, rad1_q, rad2_q;
  logic [ROOT_W-1:0]  s1, s2;
  logic signed [ZW-1:0] a0, c1, c2, t1_q, t2_q;

  logic signed [PH_W-1:0] ph1_q, ph2_q;
  logic [PL_W-1:0]        pl1_q, pl2_q;
  logic signed [P_W-1:0]  p1_q, p2_q, np1;
  logic signed [U_W-1:0]  u1_q, u2_q;
  logic                   neg1_q, neg2_q;
  logic [PROD_W-1:0]      prod1_q, prod2_q;
  logic [Q_W-1:0]         q1, q2;
  logic [PULSE_WIDTH_BITS-1:0] sat1, sat2;

  assign en    = !out_v_q || rsp_o.ready;
  assign pop_o = en && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[VLD_LEN-2:0], head_valid_i};
      out_v_q <= vld_q[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q      <= {ok_q[VLD_LEN-2:0], head_i.ok};
      side_q[0] <= '{head_i.x, head_i.y, head_i.n1, head_i.n2};
      for (int k = 1; k < SIDE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_last = side_q[SIDE_LAT-1];

  // acos(N / sqrt(D2)) = atan2(sqrt(D2 - N^2), N)
  assign an1 = ROOT_W'((head_i.n1 < 0) ? -head_i.n1 : head_i.n1);
  assign an2 = ROOT_W'((head_i.n2 < 0) ? -head_i.n2 : head_i.n2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= {head_i.d1a, 2'b00};
      d2_q   <= {2'b00, head_i.d2a, 2'b00};
      n1sq_q <= RAD_W'(an1) * RAD_W'(an1);
      n2sq_q <= RAD_W'(an2) * RAD_W'(an2);
      rad1_q <= (d1_q > n1sq_q) ? d1_q - n1sq_q : '0;
      rad2_q <= (d2_q > n2sq_q) ? d2_q - n2sq_q : '0;
    end
  end

  ika_sqrt u_sqrt1 (.clk_i, .en_i(en), .val_i(rad1_q), .root_o(s1));
  ika_sqrt u_sqrt2 (.clk_i, .en_i(en), .val_i(rad2_q), .root_o(s2));

  ika_cordic u_atan (
    .clk_i, .en_i(en),
    .y_i(VIN_W'(side_last.y)), .x_i(VIN_W'(side_last.x)), .angle_o(a0)
  );
  ika_cordic u_acos1 (
    .clk_i, .en_i(en),
    .y_i($signed(VIN_W'(s1))), .x_i(VIN_W'(side_last.n1)), .angle_o(c1)
  );
  ika_cordic u_acos2 (
    .clk_i, .en_i(en),
    .y_i($signed(VIN_W'(s2))), .x_i(VIN_W'(side_last.n2)), .angle_o(c2)
  );

  assign np1 = -p1_q;

  // Sum the angles, multiply by the gain in two partial products, keep floor(./2^32), add the offset, scale by 1/50.
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= a0 + c1;
      t2_q <= a0 + c1 - c2;

      ph1_q <= $signed(t1_q[ZW-1:16]) * $signed({1'b0, PULSE_GAIN});
      ph2_q <= $signed(t2_q[ZW-1:16]) * $signed({1'b0, PULSE_GAIN});
      pl1_q <= PL_W'(t1_q[15:0]) * PL_W'(PULSE_GAIN);
      pl2_q <= PL_W'(t2_q[15:0]) * PL_W'(PULSE_GAIN);

      p1_q <= (P_W'(ph1_q) <<< 16) + P_W'(pl1_q);
      p2_q <= (P_W'(ph2_q) <<< 16) + P_W'(pl2_q);

      u1_q <= $signed(np1[P_W-1:32]) + SH_OFS;
      u2_q <= $signed(p2_q[P_W-1:32]) + EL_OFS;

      neg1_q  <= u1_q[U_W-1];
      neg2_q  <= u2_q[U_W-1];
      prod1_q <= PROD_W'(u1_q[19:0]) * PROD_W'(RECIP);
      prod2_q <= PROD_W'(u2_q[19:0]) * PROD_W'(RECIP);
    end
  end

  assign q1 = prod1_q[PROD_W-1:RECIP_SHIFT];
  assign q2 = prod2_q[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    sat1 = PULSE_WIDTH_BITS'(q1);
    sat2 = PULSE_WIDTH_BITS'(q2);
    if (32'(q1) > 32'(PULSE_MAX)) sat1 = PULSE_WIDTH_BITS'(PULSE_MAX);
    if (32'(q2) > 32'(PULSE_MAX)) sat2 = PULSE_WIDTH_BITS'(PULSE_MAX);
    if (neg1_q) sat1 = '0;
    if (neg2_q) sat2 = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_o.in_reach       <= ok_q[VLD_LEN-1];
      rsp_o.pulse_shoulder <= ok_q[VLD_LEN-1] ? sat1 : '0;
      rsp_o.pulse_elbow    <= ok_q[VLD_LEN-1] ? sat2 : '0;
    end
  end

  assign rsp_o.valid = out_v_q;

endmodule
